### design/iff_pkg.sv
// Shared types and constants of the integer field formatter.
// Holds the conversion and length codes, ASCII constants and the digit unit command.
// Used by iff_digit_unit and integer_field_formatter_core.
`default_nettype none

package iff_pkg;

  // conversion codes
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_HEXL = 3'd3;
  localparam logic [2:0] CONV_HEXU = 3'd4;
  localparam logic [2:0] CONV_BIN  = 3'd5;
  localparam logic [2:0] CONV_PTR  = 3'd6;
  localparam logic [2:0] CONV_NONE = 3'd7;

  // length modifier codes
  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_LONG  = 2'd1;
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_CHAR  = 2'd3;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;

  // at most this many characters leave per request
  localparam int OUT_LIMIT = 64;

  typedef enum logic [1:0] {
    BASE_2,
    BASE_8,
    BASE_10,
    BASE_16
  } base_t;

  typedef struct packed {
    logic  load;
    logic  dabble;
    logic  shift;
    base_t base;
  } dig_cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else begin
      ch = (upper ? CH_UPA : CH_LOWA) + {4'b0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/iff_digit_unit.sv
// Digit register of the integer field formatter: loads the magnitude top-aligned
// for binary, octal and hex, converts decimal to BCD by shift-and-add-3, and
// shifts digits out from the top. Depends on iff_pkg.
`default_nettype none

module iff_digit_unit
  import iff_pkg::*;
#(
  parameter int INT_BITS = 32
) (
  input  logic                clk,
  input  dig_cmd_t            cmd,
  input  logic [INT_BITS-1:0] mag,
  output logic [3:0]          top_digit
);

  localparam int ND8  = (INT_BITS + 2) / 3;
  localparam int ND16 = (INT_BITS + 3) / 4;
  localparam int ND10 = (INT_BITS * 30103) / 100000 + 1;
  localparam int W8   = 3 * ND8;
  localparam int W16  = 4 * ND16;
  localparam int W10  = 4 * ND10;
  localparam int M1   = (W8 > INT_BITS) ? W8 : INT_BITS;
  localparam int M2   = (W16 > M1) ? W16 : M1;
  localparam int DREG = (W10 > M2) ? W10 : M2;

  logic [DREG-1:0]     dig_r, dig_nxt;
  logic [INT_BITS-1:0] sh_r, sh_nxt;
  logic [W10-1:0]      bcd_adj;

  always_comb begin
    dig_nxt = dig_r;
    sh_nxt  = sh_r;
    bcd_adj = dig_r[DREG-1 -: W10];
    for (int i = 0; i < ND10; i++) begin
      if (bcd_adj[4*i +: 4] > 4'd4) begin
        bcd_adj[4*i +: 4] = bcd_adj[4*i +: 4] + 4'd3;
      end
    end
    if (cmd.load) begin
      dig_nxt = '0;
      sh_nxt  = mag;
      case (cmd.base)
        BASE_2:  dig_nxt[DREG-1 -: INT_BITS] = mag;
        BASE_8:  dig_nxt[DREG-1 -: W8]       = W8'(mag);
        BASE_16: dig_nxt[DREG-1 -: W16]      = W16'(mag);
        default: ;
      endcase
    end else if (cmd.dabble) begin
      dig_nxt[DREG-1 -: W10] = {bcd_adj[W10-2:0], sh_r[INT_BITS-1]};
      sh_nxt                 = sh_r << 1;
    end else if (cmd.shift) begin
      case (cmd.base)
        BASE_2:  dig_nxt = dig_r << 1;
        BASE_8:  dig_nxt = dig_r << 3;
        default: dig_nxt = dig_r << 4;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    sh_r  <= sh_nxt;
  end

  always_comb begin
    case (cmd.base)
      BASE_2:  top_digit = {3'b0, dig_r[DREG-1]};
      BASE_8:  top_digit = {1'b0, dig_r[DREG-1 -: 3]};
      default: top_digit = dig_r[DREG-1 -: 4];
    endcase
  end

endmodule

`default_nettype wire

### design/integer_field_formatter_core.sv
// Top level of the integer field formatter: request decode, sequencer and output register.
// Depends on iff_pkg and iff_digit_unit.
`default_nettype none

// One request formats one printf-style integer conversion into ASCII characters,
// most significant first. Each character is shown for one cycle on out_valid, with
// out_last on the final one; the receiver cannot stall, and idle cycles may separate
// characters. busy stays high from the accepting edge until the last character is
// registered. After the accepting edge the sequencer runs INT_BITS shift-and-add-3
// steps for the decimal kinds (none for binary, octal, hex), drops leading zero
// digits, sizes the field, then emits leading pad, sign, prefix, inner pad, digits
// and trailing pad, at most 64 characters in all. Output pauses at the end of the
// leading pad, at an empty sign slot, at each empty prefix slot, at the end of the
// inner pad and at the end of the digits when trailing pad follows. Unused
// conversion code 7 is accepted and produces no characters.

module integer_field_formatter_core
  import iff_pkg::*;
#(
  parameter int INT_BITS        = 32,
  parameter int MAX_FIELD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic [2:0]  in_conversion,
  input  logic [1:0]  in_length_kind,
  input  logic        in_left_adjust,
  input  logic        in_plus_sign,
  input  logic        in_alt_form,
  input  logic        in_zero_fill,
  input  logic [6:0]  in_field_width,
  output logic        out_valid,
  output logic [7:0]  out_character,
  output logic        out_last
);

  localparam int ND2   = INT_BITS;
  localparam int ND8   = (INT_BITS + 2) / 3;
  localparam int ND16  = (INT_BITS + 3) / 4;
  localparam int ND10  = (INT_BITS * 30103) / 100000 + 1;
  localparam int CNT_W = $clog2(INT_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_TRIM,
    S_SIZE,
    S_PRE,
    S_SIGN,
    S_P0,
    S_PX,
    S_MID,
    S_DIG,
    S_POST
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [6:0]         nd_r, nd_nxt;
  logic [6:0]         pad_r, pad_nxt;
  logic [6:0]         tot_r, tot_nxt;
  logic [6:0]         emit_r, emit_nxt;
  logic               neg_r, neg_nxt;
  logic               plus_r, plus_nxt;
  logic               upper_r, upper_nxt;
  base_t              base_r, base_nxt;
  logic [1:0]         pfx_r, pfx_nxt;
  logic               zfill_r, zfill_nxt;
  logic               ladj_r, ladj_nxt;
  logic [6:0]         width_r, width_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_character_r, out_character_nxt;
  logic               out_last_r, out_last_nxt;

  // request decode
  logic               conv_ok;
  logic               sign_kind;
  logic               is_ptr;
  logic               upper_d;
  base_t              base_d;
  logic [63:0]        ext64;
  logic [INT_BITS-1:0] num;
  logic [INT_BITS-1:0] mag;
  logic               neg_d;
  logic               sharp_d;
  logic [6:0]         width_d;
  logic [1:0]         pfx_d;
  logic [6:0]         nd_init;

  always_comb begin
    conv_ok   = 1'b1;
    sign_kind = 1'b0;
    is_ptr    = 1'b0;
    upper_d   = 1'b0;
    base_d    = BASE_10;
    case (in_conversion)
      CONV_SDEC: sign_kind = 1'b1;
      CONV_UDEC: base_d = BASE_10;
      CONV_OCT:  base_d = BASE_8;
      CONV_HEXL: base_d = BASE_16;
      CONV_HEXU: begin
        base_d  = BASE_16;
        upper_d = 1'b1;
      end
      CONV_BIN:  base_d = BASE_2;
      CONV_PTR: begin
        base_d = BASE_16;
        is_ptr = 1'b1;
      end
      default:   conv_ok = 1'b0;
    endcase

    if (is_ptr) begin
      ext64 = {32'b0, in_value};
    end else begin
      case (in_length_kind)
        LEN_SHORT: ext64 = {{48{sign_kind & in_value[15]}}, in_value[15:0]};
        LEN_CHAR:  ext64 = {{56{sign_kind & in_value[7]}}, in_value[7:0]};
        default:   ext64 = {{32{sign_kind & in_value[31]}}, in_value};
      endcase
    end
    num   = ext64[INT_BITS-1:0];
    neg_d = num[INT_BITS-1];
    mag   = neg_d ? (INT_BITS'(0) - num) : num;

    width_d = (in_field_width > 7'(MAX_FIELD_WIDTH)) ? 7'(MAX_FIELD_WIDTH) : in_field_width;
    sharp_d = is_ptr ? (in_field_width == 7'd0) : in_alt_form;
    pfx_d   = 2'd0;
    if (sharp_d && (num != '0)) begin
      case (base_d)
        BASE_8:  pfx_d = 2'd1;
        BASE_16: pfx_d = 2'd2;
        default: pfx_d = 2'd0;
      endcase
    end

    case (base_d)
      BASE_2:  nd_init = 7'(ND2);
      BASE_8:  nd_init = 7'(ND8);
      BASE_16: nd_init = 7'(ND16);
      default: nd_init = 7'(ND10);
    endcase
  end

  logic     accept;
  dig_cmd_t dig_cmd;
  logic [3:0] top_digit;

  assign accept = start && (state_r == S_IDLE);

  iff_digit_unit #(
    .INT_BITS (INT_BITS)
  ) u_digit (
    .clk       (clk),
    .cmd       (dig_cmd),
    .mag       (mag),
    .top_digit (top_digit)
  );

  // sequencer
  logic       pre_en, mid_en, post_en;
  logic       emit;
  logic [7:0] emit_ch;
  logic       last_hit;
  logic [7:0] core_len;
  logic [7:0] width8;
  logic [7:0] pad_ch;

  assign pre_en  = !neg_r && !zfill_r;
  assign mid_en  = !pre_en && !ladj_r;
  assign post_en = !pre_en && ladj_r;
  assign pad_ch  = zfill_r ? CH_ZERO : CH_SPACE;
  assign core_len = {1'b0, nd_r} + {6'b0, pfx_r} + {7'b0, neg_r | plus_r};
  assign width8   = {1'b0, width_r};
  assign last_hit = (emit_r == (tot_r - 7'd1)) || (emit_r == 7'(OUT_LIMIT - 1));

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    nd_nxt            = nd_r;
    pad_nxt           = pad_r;
    tot_nxt           = tot_r;
    emit_nxt          = emit_r;
    neg_nxt           = neg_r;
    plus_nxt          = plus_r;
    upper_nxt         = upper_r;
    base_nxt          = base_r;
    pfx_nxt           = pfx_r;
    zfill_nxt         = zfill_r;
    ladj_nxt          = ladj_r;
    width_nxt         = width_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    emit              = 1'b0;
    emit_ch           = CH_SPACE;
    dig_cmd.load      = 1'b0;
    dig_cmd.dabble    = 1'b0;
    dig_cmd.shift     = 1'b0;
    dig_cmd.base      = base_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = neg_d;
          plus_nxt  = in_plus_sign & sign_kind;
          upper_nxt = upper_d;
          base_nxt  = base_d;
          pfx_nxt   = pfx_d;
          zfill_nxt = in_zero_fill;
          ladj_nxt  = in_left_adjust;
          width_nxt = width_d;
          nd_nxt    = nd_init;
          cnt_nxt   = CNT_W'(INT_BITS - 1);
          if (conv_ok) begin
            dig_cmd.load = 1'b1;
            dig_cmd.base = base_d;
            state_nxt    = (base_d == BASE_10) ? S_DEC : S_TRIM;
          end
        end
      end
      S_DEC: begin
        dig_cmd.dabble = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_TRIM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_TRIM: begin
        // drop leading zero digits, keep at least one
        if ((top_digit == 4'd0) && (nd_r > 7'd1)) begin
          dig_cmd.shift = 1'b1;
          nd_nxt        = nd_r - 7'd1;
        end else begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        pad_nxt   = (width8 > core_len) ? 7'(width8 - core_len) : 7'd0;
        tot_nxt   = (width8 > core_len) ? width_r : 7'(core_len);
        emit_nxt  = 7'd0;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        if (pre_en && (pad_r != 7'd0)) begin
          emit    = 1'b1;
          emit_ch = pad_ch;
          pad_nxt = pad_r - 7'd1;
        end else begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        state_nxt = S_P0;
        if (neg_r) begin
          emit    = 1'b1;
          emit_ch = CH_MINUS;
        end else if (plus_r) begin
          emit    = 1'b1;
          emit_ch = CH_PLUS;
        end
      end
      S_P0: begin
        state_nxt = S_PX;
        if (pfx_r != 2'd0) begin
          emit    = 1'b1;
          emit_ch = CH_ZERO;
        end
      end
      S_PX: begin
        state_nxt = S_MID;
        if (pfx_r == 2'd2) begin
          emit    = 1'b1;
          emit_ch = CH_X;
        end
      end
      S_MID: begin
        if (mid_en && (pad_r != 7'd0)) begin
          emit    = 1'b1;
          emit_ch = pad_ch;
          pad_nxt = pad_r - 7'd1;
        end else begin
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (nd_r != 7'd0) begin
          emit          = 1'b1;
          emit_ch       = digit_char(top_digit, upper_r);
          dig_cmd.shift = 1'b1;
          nd_nxt        = nd_r - 7'd1;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (post_en && (pad_r != 7'd0)) begin
          emit    = 1'b1;
          emit_ch = pad_ch;
          pad_nxt = pad_r - 7'd1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_character_nxt = emit_ch;
      out_last_nxt      = last_hit;
      emit_nxt          = emit_r + 7'd1;
      // stop at the end of the field or at the character limit
      if (last_hit) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r           <= cnt_nxt;
    nd_r            <= nd_nxt;
    pad_r           <= pad_nxt;
    tot_r           <= tot_nxt;
    emit_r          <= emit_nxt;
    neg_r           <= neg_nxt;
    plus_r          <= plus_nxt;
    upper_r         <= upper_nxt;
    base_r          <= base_nxt;
    pfx_r           <= pfx_nxt;
    zfill_r         <= zfill_nxt;
    ladj_r          <= ladj_nxt;
    width_r         <= width_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_out_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("character emitted without a request in progress");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy after the last character");

  a_bad_conv_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_conversion == CONV_NONE)) |=> (!busy && !out_valid))
    else $error("unused conversion code started work");

  a_fill_digits_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |-> (nd_r == 7'(ND10)))
    else $error("digit count disturbed during BCD conversion");
`endif

endmodule

`default_nettype wire

### tb/integer_field_formatter_core_tb.sv
// Self-checking testbench for integer_field_formatter_core: directed and random requests,
// each predicted into its expected character stream and compared as characters leave.
// Depends on iff_pkg and the formatter RTL only.
`default_nettype none

module integer_field_formatter_core_tb
  import iff_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FIELD_CAP    = 64;
  localparam int          RANDOM_REQS  = 220;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          QUIET_CYCLES = 200;

  // Expected characters of every accepted request, oldest first.
  class field_text_board;
    logic [7:0] pending_chars[$];
    logic       pending_last[$];
    int         errors;

    function void format_request(logic [31:0] value, logic [2:0] conv, logic [1:0] len,
                                 logic ladj, logic plus_in, logic alt, logic zfill,
                                 logic [6:0] fw);
      string       digit_set;
      int          width, nd, prefix, pad, i;
      logic [31:0] base, num, t, d;
      logic        neg, upper, plus, sharp;
      logic [7:0]  padc, ch;
      logic [7:0]  digs[$];
      logic [7:0]  text[$];
      digit_set = "0123456789abcdef";
      width = (fw > FIELD_CAP) ? FIELD_CAP : int'(fw);
      case (conv)
        CONV_SDEC, CONV_UDEC: base = 10;
        CONV_OCT:             base = 8;
        CONV_HEXL, CONV_HEXU, CONV_PTR: base = 16;
        CONV_BIN:             base = 2;
        default:              return;
      endcase
      upper = (conv == CONV_HEXU);
      plus  = plus_in && (conv == CONV_SDEC);
      padc  = zfill ? CH_ZERO : CH_SPACE;

      if (conv == CONV_PTR) begin
        sharp = (width == 0);
        num   = value;
      end else begin
        sharp = alt;
        case (len)
          LEN_SHORT: num = (conv == CONV_SDEC) ? {{16{value[15]}}, value[15:0]}
                                               : {16'b0, value[15:0]};
          LEN_CHAR:  num = (conv == CONV_SDEC) ? {{24{value[7]}}, value[7:0]}
                                               : {24'b0, value[7:0]};
          default:   num = value;
        endcase
      end

      // top bit set prints as a negative magnitude, whatever the kind
      neg = num[31];
      if (neg) num = -num;

      t = num;
      do begin
        d  = t % base;
        ch = digit_set[d[3:0]];
        if (upper && ch >= CH_LOWA) ch = ch - 8'h20;
        digs.push_front(ch);
        t = t / base;
      end while (t != 0);
      nd = digs.size();

      prefix = 0;
      if (sharp && num != 0) prefix = (base == 8) ? 1 : (base == 16) ? 2 : 0;
      pad = width - (nd + prefix + ((neg || plus) ? 1 : 0));
      if (pad < 0) pad = 0;

      if (!neg && !zfill) for (i = 0; i < pad; i++) text.push_back(padc);
      if (neg) text.push_back(CH_MINUS);
      else if (plus) text.push_back(CH_PLUS);
      if (prefix >= 1) text.push_back(CH_ZERO);
      if (prefix == 2) text.push_back(CH_X);
      if ((neg || zfill) && !ladj) for (i = 0; i < pad; i++) text.push_back(padc);
      for (i = 0; i < nd; i++) text.push_back(digs[i]);
      if ((neg || zfill) && ladj) for (i = 0; i < pad; i++) text.push_back(padc);

      // drop anything past the output limit; the last kept character is marked
      while (text.size() > OUT_LIMIT) void'(text.pop_back());
      for (i = 0; i < text.size(); i++) begin
        pending_chars.push_back(text[i]);
        pending_last.push_back(i == text.size() - 1);
      end
    endfunction

    function void match_char(logic [7:0] ch, logic lst);
      logic [7:0] exp_ch;
      logic       exp_lst;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, ch, lst);
        return;
      end
      exp_ch  = pending_chars.pop_front();
      exp_lst = pending_last.pop_front();
      if (ch !== exp_ch) begin
        errors++;
        $display("%0t: character mismatch: expected %h actual %h", $time, exp_ch, ch);
      end
      if (lst !== exp_lst) begin
        errors++;
        $display("%0t: last mismatch: expected %b actual %b", $time, exp_lst, lst);
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_value;
  logic [2:0]  in_conversion;
  logic [1:0]  in_length_kind;
  logic        in_left_adjust;
  logic        in_plus_sign;
  logic        in_alt_form;
  logic        in_zero_fill;
  logic [6:0]  in_field_width;
  logic        out_valid;
  logic [7:0]  out_character;
  logic        out_last;

  field_text_board board;
  int unsigned     cycle_count;

  integer_field_formatter_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_conversion  (in_conversion),
    .in_length_kind (in_length_kind),
    .in_left_adjust (in_left_adjust),
    .in_plus_sign   (in_plus_sign),
    .in_alt_form    (in_alt_form),
    .in_zero_fill   (in_zero_fill),
    .in_field_width (in_field_width),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Note requests and check characters on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        board.format_request(in_value, in_conversion, in_length_kind, in_left_adjust,
                             in_plus_sign, in_alt_form, in_zero_fill, in_field_width);
      if (out_valid)
        board.match_char(out_character, out_last);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request at a falling edge and hold it until it is taken.
  task automatic send_req(logic [31:0] value, logic [2:0] conv, logic [1:0] len,
                          logic ladj, logic plus, logic alt, logic zfill, logic [6:0] fw);
    start          = 1'b1;
    in_value       = value;
    in_conversion  = conv;
    in_length_kind = len;
    in_left_adjust = ladj;
    in_plus_sign   = plus;
    in_alt_form    = alt;
    in_zero_fill   = zfill;
    in_field_width = fw;
    // busy is stable between edges, so a low busy here means the next edge takes it
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    int          sent, burst, kind;
    logic [31:0] value;
    logic [2:0]  conv;
    logic [6:0]  fw;

    board          = new();
    cycle_count    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    in_conversion  = CONV_SDEC;
    in_length_kind = LEN_INT;
    in_left_adjust = 1'b0;
    in_plus_sign   = 1'b0;
    in_alt_form    = 1'b0;
    in_zero_fill   = 1'b0;
    in_field_width = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, every kind, padding placement, length rules
    send_req(32'd0,         CONV_SDEC, LEN_INT,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    send_req(32'h7FFF_FFFF, CONV_SDEC, LEN_LONG,  1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
    send_req(32'h8000_0000, CONV_SDEC, LEN_INT,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    send_req(32'hFFFF_FFFF, CONV_UDEC, LEN_INT,   1'b0, 1'b1, 1'b0, 1'b0, 7'd4);
    send_req(32'd123,       CONV_SDEC, LEN_INT,   1'b0, 1'b1, 1'b0, 1'b0, 7'd8);
    send_req(-32'sd5,       CONV_SDEC, LEN_INT,   1'b0, 1'b0, 1'b0, 1'b1, 7'd6);
    send_req(-32'sd5,       CONV_SDEC, LEN_INT,   1'b1, 1'b0, 1'b0, 1'b0, 7'd6);
    send_req(32'd42,        CONV_SDEC, LEN_INT,   1'b1, 1'b0, 1'b0, 1'b0, 7'd6);
    send_req(32'd42,        CONV_UDEC, LEN_INT,   1'b1, 1'b0, 1'b0, 1'b1, 7'd6);
    send_req(32'd8,         CONV_OCT,  LEN_INT,   1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
    send_req(32'd0,         CONV_OCT,  LEN_INT,   1'b0, 1'b0, 1'b1, 1'b0, 7'd3);
    send_req(32'h5EAD_BEEF, CONV_HEXL, LEN_INT,   1'b0, 1'b0, 1'b1, 1'b1, 7'd12);
    send_req(32'h00AB_CDEF, CONV_HEXU, LEN_INT,   1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
    send_req(32'hDEAD_BEEF, CONV_HEXL, LEN_INT,   1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
    send_req(32'hFFFF_FFFE, CONV_BIN,  LEN_INT,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    send_req(32'h7FFF_FFFF, CONV_BIN,  LEN_INT,   1'b0, 1'b0, 1'b0, 1'b1, 7'd64);
    send_req(32'd5,         CONV_BIN,  LEN_INT,   1'b1, 1'b0, 1'b0, 1'b1, 7'd64);
    send_req(32'h1234_ABCD, CONV_PTR,  LEN_CHAR,  1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
    send_req(32'h0000_00FF, CONV_PTR,  LEN_SHORT, 1'b0, 1'b0, 1'b1, 1'b1, 7'd10);
    send_req(32'h0001_8000, CONV_SDEC, LEN_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    send_req(32'h0001_FFFF, CONV_UDEC, LEN_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    send_req(32'h0000_01FF, CONV_SDEC, LEN_CHAR,  1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
    send_req(32'h0000_01FF, CONV_OCT,  LEN_CHAR,  1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
    send_req(32'd7,         CONV_SDEC, LEN_INT,   1'b0, 1'b0, 1'b0, 1'b0, 7'd127);
    send_req(-32'sd9,       CONV_SDEC, LEN_INT,   1'b1, 1'b0, 1'b0, 1'b1, 7'd65);
    send_req(32'hFFFF_FFFF, CONV_NONE, LEN_LONG,  1'b1, 1'b1, 1'b1, 1'b1, 7'd127);
    send_req(32'd99,        CONV_UDEC, LEN_INT,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);

    // random bursts with random gaps between them
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        kind = $urandom_range(0, 7);
        case (kind)
          0, 1:    value = $urandom();
          2:       value = $urandom_range(0, 255);
          3:       value = 32'hFFFF_FF00 | $urandom_range(0, 255);
          4:       value = 32'h1 << $urandom_range(0, 31);
          5:       value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          6:       value = {16'($urandom_range(0, 65535)), 8'h00,
                            8'h80 | 8'($urandom_range(0, 127))};
          default: value = $urandom_range(0, 65535);
        endcase
        conv = ($urandom_range(0, 19) == 0) ? CONV_NONE
                                            : 3'($urandom_range(CONV_SDEC, CONV_PTR));
        kind = $urandom_range(0, 19);
        if (kind < 10)      fw = 7'($urandom_range(0, 12));
        else if (kind < 15) fw = 7'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(13, 40));
        else if (kind < 18) fw = 7'($urandom_range(41, 64));
        else                fw = 7'($urandom_range(65, 127));
        send_req(value, conv, 2'($urandom_range(LEN_INT, LEN_CHAR)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fw);
        if (conv != CONV_NONE) sent++;
      end
      // keep some bursts back to back
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 20));
    end
    start = 1'b0;

    // drain, then stay quiet long enough to catch stray characters
    while (board.pending() != 0 || busy) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
